[rtl/egvs_pkg.sv]
`default_nettype none

package egvs_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int FLEN_W     = 13;
    localparam int THR_W      = 16;
    localparam int SIL_W      = 10;
    localparam int MAXF_W     = 12;
    localparam int COOLF_W    = 10;
    localparam int CAP_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int RMS_W      = 16;
    localparam int EVENT_W    = 2;

    // Datapath widths: sum of squares, divide/root work word, shared subtractor
    localparam int SUM_W      = 43;
    localparam int WORK_W     = SUM_W + 1;
    localparam int ROOT_W     = WORK_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SUB_W      = REM_W + 2;
    localparam int COOL_W     = COOLF_W + FLEN_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [RMS_W-1:0] RMS_SAT = 16'hFFFF;

    // Parameter defaults
    localparam int MAX_FRAME_LEN_DEF      = 4096;
    localparam int MAX_BUFFER_SAMPLES_DEF = 1048576;

    // Register reset values
    localparam logic [FLEN_W-1:0]  FRAME_LEN_RST       = 13'd661;
    localparam logic [THR_W-1:0]   RMS_THRESHOLD_RST   = 16'd80;
    localparam logic [SIL_W-1:0]   SILENCE_FRAMES_RST  = 10'd30;
    localparam logic [MAXF_W-1:0]  MAX_FRAMES_RST      = 12'd200;
    localparam logic [COOLF_W-1:0] COOLDOWN_FRAMES_RST = 10'd50;
    localparam logic [CAP_W-1:0]   BUFFER_CAPACITY_RST = 20'd132300;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LEN       = 3'd0,
        REG_RMS_THRESHOLD   = 3'd1,
        REG_SILENCE_FRAMES  = 3'd2,
        REG_MAX_FRAMES      = 3'd3,
        REG_COOLDOWN_FRAMES = 3'd4,
        REG_BUFFER_CAPACITY = 3'd5
    } reg_idx_t;

    // Frame events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE        = 2'd0,
        EV_START       = 2'd1,
        EV_END_SILENCE = 2'd2,
        EV_END_LENGTH  = 2'd3
    } event_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ACC    = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_ROOT   = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/energy_gate_voice_segmenter_unit.sv]
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  sample
// out      output     out_valid/ out_stall frame_rms, event_res, frame_kept,
//                                          active, utterance_samples
// cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// A sample in cooldown only counts the cooldown down; others are squared and summed.
// A sample that closes a frame adds 43 divide steps and 22 root steps on the one
// shared subtractor, then a decision that waits while out_stall blocks the output.
// The output register holds a word until it is taken; new samples are taken meanwhile.
// Reset clears control state, not payload registers, and loads the register defaults.

module energy_gate_voice_segmenter_unit #(
    parameter int MAX_FRAME_LEN      = egvs_pkg::MAX_FRAME_LEN_DEF,
    parameter int MAX_BUFFER_SAMPLES = egvs_pkg::MAX_BUFFER_SAMPLES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // sample channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [egvs_pkg::SAMPLE_W-1:0] sample,
    // frame result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [egvs_pkg::RMS_W-1:0]            frame_rms,
    output logic [egvs_pkg::EVENT_W-1:0]          event_res,
    output logic                                  frame_kept,
    output logic                                  active,
    output logic [egvs_pkg::CAP_W-1:0]            utterance_samples,
    // register writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [egvs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [egvs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import egvs_pkg::*;

    // Configuration registers
    logic [FLEN_W-1:0]  frame_len_reg;
    logic [THR_W-1:0]   rms_threshold_reg;
    logic [SIL_W-1:0]   silence_frames_reg;
    logic [MAXF_W-1:0]  max_frames_reg;
    logic [COOLF_W-1:0] cooldown_frames_reg;
    logic [CAP_W-1:0]   buffer_capacity_reg;

    // Sequencer and datapath
    state_t             state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [FLEN_W-1:0]  pos_reg, pos_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Utterance state
    logic               in_utt_reg, in_utt_next;
    logic [SIL_W-1:0]   quiet_reg, quiet_next;
    logic [MAXF_W-1:0]  utt_frames_reg, utt_frames_next;
    logic [CAP_W-1:0]   stored_reg, stored_next;
    logic [COOL_W-1:0]  cool_reg, cool_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [RMS_W-1:0]   rms_out_reg, rms_out_next;
    logic [EVENT_W-1:0] event_out_reg, event_out_next;
    logic               kept_out_reg, kept_out_next;
    logic               active_out_reg, active_out_next;
    logic [CAP_W-1:0]   count_out_reg, count_out_next;

    // Effective frame length and store capacity
    logic [FLEN_W-1:0]  eff_len;
    logic [CAP_W-1:0]   cap;

    always_comb
    begin
        if (frame_len_reg == '0)
            eff_len = FLEN_W'(1);
        else if (32'(frame_len_reg) > 32'(MAX_FRAME_LEN))
            eff_len = FLEN_W'(MAX_FRAME_LEN);
        else
            eff_len = frame_len_reg;

        if (32'(buffer_capacity_reg) > 32'(MAX_BUFFER_SAMPLES))
            cap = CAP_W'(MAX_BUFFER_SAMPLES);
        else
            cap = buffer_capacity_reg;
    end

    // Shared subtract/compare unit: restoring divide step or root step
    logic [SUB_W-1:0]   sub_a, sub_b;
    logic [SUB_W:0]     sub_diff;
    logic               sub_ge;

    always_comb
    begin
        case (state_reg)
            ST_DIV:
            begin
                sub_a = SUB_W'({rem_reg[FLEN_W-1:0], work_reg[SUM_W-1]});
                sub_b = SUB_W'(eff_len);
            end
            default:
            begin
                sub_a = {rem_reg, work_reg[WORK_W-1 -: 2]};
                sub_b = {1'b0, root_reg, 2'b01};
            end
        endcase
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = ~sub_diff[SUB_W];
    end

    // Accumulate path
    logic [SQ_W-1:0]    square;
    logic [SUM_W-1:0]   sum_inc;
    logic [FLEN_W-1:0]  pos_inc;

    assign square  = mag_reg * mag_reg;
    assign sum_inc = sum_reg + SUM_W'(square);
    assign pos_inc = pos_reg + FLEN_W'(1);

    // Frame decision path
    logic [RMS_W-1:0]   rms_sat;
    logic               voice, starting, open_n, fits, len_limit, silent, ending;
    logic [CAP_W-1:0]   stored_base, stored_upd;
    logic [MAXF_W-1:0]  frames_upd;
    logic [SIL_W-1:0]   quiet_upd;
    logic [CAP_W:0]     stored_sum;
    logic               out_blocked;

    always_comb
    begin
        rms_sat     = (root_reg[ROOT_W-1:RMS_W] != '0) ? RMS_SAT : root_reg[RMS_W-1:0];
        voice       = rms_sat >= rms_threshold_reg;
        starting    = voice && !in_utt_reg;
        open_n      = voice || in_utt_reg;
        stored_base = starting ? '0 : stored_reg;
        stored_sum  = {1'b0, stored_base} + (CAP_W + 1)'(eff_len);
        fits        = open_n && (stored_sum <= {1'b0, cap});
        stored_upd  = fits ? stored_sum[CAP_W-1:0] : stored_base;
        frames_upd  = starting ? MAXF_W'(1)
                    : (open_n ? utt_frames_reg + MAXF_W'(1) : utt_frames_reg);
        if (voice)
            quiet_upd = '0;
        else if (in_utt_reg)
            quiet_upd = quiet_reg + SIL_W'(1);
        else
            quiet_upd = quiet_reg;
        len_limit   = frames_upd >= max_frames_reg;
        silent      = quiet_upd >= silence_frames_reg;
        ending      = open_n && (len_limit || silent);
        out_blocked = out_valid_reg && out_stall;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        sum_next        = sum_reg;
        pos_next        = pos_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        cnt_next        = cnt_reg;
        in_utt_next     = in_utt_reg;
        quiet_next      = quiet_reg;
        utt_frames_next = utt_frames_reg;
        stored_next     = stored_reg;
        cool_next       = cool_reg;
        out_valid_next  = out_blocked;
        rms_out_next    = rms_out_reg;
        event_out_next  = event_out_reg;
        kept_out_next   = kept_out_reg;
        active_out_next = active_out_reg;
        count_out_next  = count_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cool_reg != '0)
                        cool_next = cool_reg - COOL_W'(1);
                    else
                    begin
                        mag_next   = sample[SAMPLE_W-1] ? (~sample + MAG_W'(1)) : sample;
                        state_next = ST_ACC;
                    end
                end
            end

            ST_ACC:
            begin
                if (pos_inc >= eff_len)
                begin
                    // frame complete: start the divide on the finished sum
                    work_next  = {1'b0, sum_inc};
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    sum_next   = '0;
                    pos_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    sum_next   = sum_inc;
                    pos_next   = pos_inc;
                    state_next = ST_IDLE;
                end
            end

            ST_DIV:
            begin
                // one quotient bit per cycle, shifted in behind the dividend
                work_next = {1'b0, work_reg[SUM_W-2:0], sub_ge};
                rem_next  = REM_W'(sub_ge ? sub_diff[FLEN_W-1:0] : sub_a[FLEN_W-1:0]);
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_STEPS - 1);
                    state_next = ST_ROOT;
                end
            end

            ST_ROOT:
            begin
                // one root bit per cycle from the top two quotient bits
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                rem_next  = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (!out_blocked)
                begin
                    rms_out_next   = rms_sat;
                    kept_out_next  = fits;
                    count_out_next = stored_upd;
                    out_valid_next = 1'b1;
                    if (ending)
                    begin
                        event_out_next  = len_limit ? EV_END_LENGTH : EV_END_SILENCE;
                        active_out_next = 1'b0;
                        in_utt_next     = 1'b0;
                        stored_next     = '0;
                        utt_frames_next = '0;
                        quiet_next      = '0;
                        cool_next       = COOL_W'(cooldown_frames_reg) * COOL_W'(eff_len);
                    end
                    else
                    begin
                        event_out_next  = starting ? EV_START : EV_NONE;
                        active_out_next = open_n;
                        in_utt_next     = open_n;
                        stored_next     = stored_upd;
                        utt_frames_next = frames_upd;
                        quiet_next      = quiet_upd;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sum_reg        <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            in_utt_reg     <= 1'b0;
            quiet_reg      <= '0;
            utt_frames_reg <= '0;
            stored_reg     <= '0;
            cool_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sum_reg        <= sum_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            in_utt_reg     <= in_utt_next;
            quiet_reg      <= quiet_next;
            utt_frames_reg <= utt_frames_next;
            stored_reg     <= stored_next;
            cool_reg       <= cool_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        work_reg       <= work_next;
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        rms_out_reg    <= rms_out_next;
        event_out_reg  <= event_out_next;
        kept_out_reg   <= kept_out_next;
        active_out_reg <= active_out_next;
        count_out_reg  <= count_out_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg       <= FRAME_LEN_RST;
            rms_threshold_reg   <= RMS_THRESHOLD_RST;
            silence_frames_reg  <= SILENCE_FRAMES_RST;
            max_frames_reg      <= MAX_FRAMES_RST;
            cooldown_frames_reg <= COOLDOWN_FRAMES_RST;
            buffer_capacity_reg <= BUFFER_CAPACITY_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_LEN:       frame_len_reg       <= cfg_data[FLEN_W-1:0];
                REG_RMS_THRESHOLD:   rms_threshold_reg   <= cfg_data[THR_W-1:0];
                REG_SILENCE_FRAMES:  silence_frames_reg  <= cfg_data[SIL_W-1:0];
                REG_MAX_FRAMES:      max_frames_reg      <= cfg_data[MAXF_W-1:0];
                REG_COOLDOWN_FRAMES: cooldown_frames_reg <= cfg_data[COOLF_W-1:0];
                REG_BUFFER_CAPACITY: buffer_capacity_reg <= cfg_data[CAP_W-1:0];
                default:             ;
            endcase
        end
    end

    // Ports
    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign frame_rms         = rms_out_reg;
    assign event_res         = event_out_reg;
    assign frame_kept        = kept_out_reg;
    assign active            = active_out_reg;
    assign utterance_samples = count_out_reg;

endmodule

`default_nettype wire
